[rtl/hcs_pkg.sv]
package hcs_pkg;

    // Calendar geometry: every level below the top has a main and a backup bank.
    localparam int LEVEL_COUNT       = 5;
    localparam int TOP_LEVEL         = LEVEL_COUNT - 1;
    localparam int LOG_F             = 3;
    localparam int BUCKETS_PER_LEVEL = 1 << LOG_F;
    localparam int BANK_COUNT        = 2 * (LEVEL_COUNT - 1) + 1;
    localparam int BUCKET_COUNT      = BANK_COUNT * BUCKETS_PER_LEVEL;
    localparam int BKT_W             = $clog2(BUCKET_COUNT);
    localparam int LVL_W             = 3;

    // Flows and weights.
    localparam int FLOW_SLOTS   = 64;
    localparam int FLOW_W       = 6;
    localparam int WEIGHT_SLOTS = 4;
    localparam int WSEL_W       = 2;

    // Field and register widths.
    localparam int HANDLE_W  = 16;
    localparam int ROUND_W   = 32;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // Serving arithmetic: the divider is at most F^TOP_LEVEL.
    localparam int DIV_W      = LOG_F * TOP_LEVEL + 1;
    localparam int ACC_W      = DIV_W + 1;
    localparam int SCAN_LIMIT = 131072;
    localparam int SCAN_W     = $clog2(SCAN_LIMIT + 1);

    localparam int DEF_BUCKET_SLOTS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT0 = 3'd0,
        CFG_WEIGHT1 = 3'd1,
        CFG_WEIGHT2 = 3'd2,
        CFG_WEIGHT3 = 3'd3,
        CFG_BURST   = 3'd4
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED      = 3'd0,
        ST_BURST_DROP  = 3'd1,
        ST_LEVEL_DROP  = 3'd2,
        ST_BUCKET_FULL = 3'd3,
        ST_DEQUEUED    = 3'd4,
        ST_EMPTY       = 3'd5
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    enq_dep;
        logic    enq_chk;
        logic    climb_step;
        logic    climb_done;
        logic    enq_commit;
        logic    deq_start;
        logic    srv_rd;
        logic    srv_occ;
        logic    srv_move;
        logic    srv_wb;
        logic    round_inc;
        logic    lvl_dec;
        logic    pop_wr;
        logic    status_we;
        status_t status;
        logic    load_out;
    } cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic burst_drop;
        logic climb_gt;
        logic climb_top;
        logic bucket_full;
        logic pending_zero;
        logic list_empty;
        logic take_more;
        logic level_end;
        logic scan_more;
        logic out_free;
    } stat_t;

endpackage

[rtl/hcs_ctrl.sv]
module hcs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           in_op,
    output logic           in_ready,
    input  hcs_pkg::stat_t stat,
    output hcs_pkg::cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_ENQ_RD   = 15'b000000000000010,
        S_ENQ_CHK  = 15'b000000000000100,
        S_CLIMB    = 15'b000000000001000,
        S_ENQ_BKT  = 15'b000000000010000,
        S_DEQ      = 15'b000000000100000,
        S_SRV_RD   = 15'b000000001000000,
        S_SRV_OCC  = 15'b000000010000000,
        S_SRV_TAKE = 15'b000000100000000,
        S_SRV_MOVE = 15'b000001000000000,
        S_SRV_NEXT = 15'b000010000000000,
        S_DEQ_END  = 15'b000100000000000,
        S_POP      = 15'b001000000000000,
        S_POP_WR   = 15'b010000000000000,
        S_FIN      = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = in_op ? S_DEQ : S_ENQ_RD;
                end
            end
            S_ENQ_RD: begin
                cmd.enq_dep = 1'b1;
                state_next  = S_ENQ_CHK;
            end
            S_ENQ_CHK: begin
                if (stat.burst_drop) begin
                    cmd.status_we = 1'b1;
                    cmd.status    = hcs_pkg::ST_BURST_DROP;
                    state_next    = S_FIN;
                end else begin
                    cmd.enq_chk = 1'b1;
                    state_next  = S_CLIMB;
                end
            end
            S_CLIMB: begin
                if (stat.climb_gt && stat.climb_top) begin
                    cmd.status_we = 1'b1;
                    cmd.status    = hcs_pkg::ST_LEVEL_DROP;
                    state_next    = S_FIN;
                end else if (stat.climb_gt) begin
                    cmd.climb_step = 1'b1;
                end else begin
                    cmd.climb_done = 1'b1;
                    state_next     = S_ENQ_BKT;
                end
            end
            S_ENQ_BKT: begin
                cmd.status_we = 1'b1;
                if (stat.bucket_full) begin
                    cmd.status = hcs_pkg::ST_BUCKET_FULL;
                end else begin
                    cmd.enq_commit = 1'b1;
                    cmd.status     = hcs_pkg::ST_QUEUED;
                end
                state_next = S_FIN;
            end
            S_DEQ: begin
                if (stat.pending_zero) begin
                    cmd.status_we = 1'b1;
                    cmd.status    = hcs_pkg::ST_EMPTY;
                    state_next    = S_FIN;
                end else if (!stat.list_empty) begin
                    state_next = S_POP;
                end else begin
                    cmd.deq_start = 1'b1;
                    state_next    = S_SRV_RD;
                end
            end
            S_SRV_RD: begin
                cmd.srv_rd = 1'b1;
                state_next = S_SRV_OCC;
            end
            S_SRV_OCC: begin
                cmd.srv_occ = 1'b1;
                state_next  = S_SRV_TAKE;
            end
            S_SRV_TAKE: begin
                if (stat.take_more) begin
                    state_next = S_SRV_MOVE;
                end else begin
                    cmd.srv_wb = 1'b1;
                    state_next = S_SRV_NEXT;
                end
            end
            S_SRV_MOVE: begin
                cmd.srv_move = 1'b1;
                state_next   = S_SRV_TAKE;
            end
            S_SRV_NEXT: begin
                if (!stat.level_end) begin
                    cmd.lvl_dec = 1'b1;
                    state_next  = S_SRV_RD;
                end else if (stat.scan_more) begin
                    cmd.round_inc = 1'b1;
                    state_next    = S_SRV_RD;
                end else begin
                    state_next = S_DEQ_END;
                end
            end
            S_DEQ_END: begin
                if (stat.list_empty) begin
                    cmd.status_we = 1'b1;
                    cmd.status    = hcs_pkg::ST_EMPTY;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                state_next = S_POP_WR;
            end
            S_POP_WR: begin
                cmd.pop_wr    = 1'b1;
                cmd.status_we = 1'b1;
                cmd.status    = hcs_pkg::ST_DEQUEUED;
                state_next    = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/hcs_datapath.sv]
module hcs_datapath #(
    parameter int BUCKET_SLOTS = hcs_pkg::DEF_BUCKET_SLOTS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hcs_pkg::cmd_t                      cmd,
    output hcs_pkg::stat_t                     stat,
    input  logic [hcs_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                               cfg_wen,
    input  logic [hcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcs_pkg::REG_W-1:0]          cfg_wdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hcs_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [hcs_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int STORE_DEPTH = hcs_pkg::BUCKET_COUNT * BUCKET_SLOTS;
    localparam int ST_W        = $clog2(STORE_DEPTH);
    localparam int PEND_W      = $clog2(STORE_DEPTH + 1);
    localparam int FILL_W      = $clog2(BUCKET_SLOTS + 1);
    localparam int HEAD_W      = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int SUM_W       = FILL_W + 1;
    localparam int DEP_W       = hcs_pkg::ROUND_W + 1;
    localparam int FLOW_ENT_W  = hcs_pkg::ROUND_W + hcs_pkg::LVL_W;
    localparam int BKT_ENT_W   = HEAD_W + FILL_W;
    localparam int LVL_W       = hcs_pkg::LVL_W;
    localparam int BKT_W       = hcs_pkg::BKT_W;

    // Bucket number from level, bank parity and index within the level.
    function automatic logic [BKT_W-1:0] bucket_of(
        input logic [LVL_W-1:0]          lvl,
        input logic                      backup,
        input logic [hcs_pkg::LOG_F-1:0] idx
    );
        logic [BKT_W-1:0] bank;
        if (lvl == LVL_W'(hcs_pkg::TOP_LEVEL)) begin
            bank = BKT_W'(2 * hcs_pkg::TOP_LEVEL);
        end else begin
            bank = BKT_W'({lvl, backup});
        end
        return BKT_W'((bank << hcs_pkg::LOG_F) | BKT_W'(idx));
    endfunction

    // Configuration registers.
    logic [hcs_pkg::REG_W-1:0] weight_reg [hcs_pkg::WEIGHT_SLOTS];
    logic [hcs_pkg::REG_W-1:0] burst_reg;

    // Control state.
    logic [hcs_pkg::ROUND_W-1:0] round_now_reg;
    logic [PEND_W-1:0]           pending_reg;
    logic [PEND_W-1:0]           list_fill_reg;
    logic [PEND_W-1:0]           list_head_reg;
    logic [hcs_pkg::SCAN_W-1:0]  scanned_reg;
    logic [hcs_pkg::FLOW_SLOTS-1:0]   flow_vld_reg;
    logic [hcs_pkg::BUCKET_COUNT-1:0] bkt_vld_reg;
    logic                        m_valid_reg;

    // Working registers.
    logic [hcs_pkg::FLOW_W-1:0]   fid_reg;
    logic [hcs_pkg::HANDLE_W-1:0] handle_reg;
    logic [DEP_W-1:0]             dep_reg;
    logic [DEP_W-1:0]             d_reg;
    logic [DEP_W-1:0]             c_reg;
    logic [LVL_W-1:0]             lvl_reg;
    logic                         lvl0_top_reg;
    logic [BKT_W-1:0]             bucket_reg;
    logic [FILL_W-1:0]            bfill_reg;
    logic [HEAD_W-1:0]            bhead_reg;
    logic [FILL_W-1:0]            occ_reg;
    logic [hcs_pkg::ACC_W-1:0]    acc_reg;
    logic [hcs_pkg::DIV_W-1:0]    div_reg;
    logic [hcs_pkg::STATUS_W-1:0] status_reg;
    logic [hcs_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [hcs_pkg::STATUS_W-1:0] m_user_reg;
    logic [hcs_pkg::OUT_DATA_W-1:0] m_data_reg;

    // Memories and their registered read data.
    logic [FLOW_ENT_W-1:0]        flow_mem  [hcs_pkg::FLOW_SLOTS];
    logic [BKT_ENT_W-1:0]         bkt_mem   [hcs_pkg::BUCKET_COUNT];
    logic [hcs_pkg::HANDLE_W-1:0] store_mem [STORE_DEPTH];
    logic [hcs_pkg::HANDLE_W-1:0] list_mem  [STORE_DEPTH];
    logic [FLOW_ENT_W-1:0]        flow_rd_reg;
    logic                         flow_rd_vld_reg;
    logic [BKT_ENT_W-1:0]         bkt_rd_reg;
    logic                         bkt_rd_vld_reg;
    logic [hcs_pkg::HANDLE_W-1:0] store_rd_reg;
    logic [hcs_pkg::HANDLE_W-1:0] list_rd_reg;

    // Combinational values.
    logic [hcs_pkg::FLOW_W-1:0]   fid_in;
    logic [hcs_pkg::HANDLE_W-1:0] handle_in;
    logic [hcs_pkg::ROUND_W-1:0]  flow_last;
    logic [LVL_W-1:0]             flow_lvl;
    logic [hcs_pkg::ROUND_W-1:0]  last_max;
    logic [DEP_W-1:0]             dep_next;
    logic [DEP_W-1:0]             gap;
    logic [DEP_W-1:0]             climb_diff;
    logic [BKT_W-1:0]             enq_bucket;
    logic [hcs_pkg::ROUND_W-1:0]  srv_shift;
    logic [BKT_W-1:0]             srv_bucket;
    logic [hcs_pkg::DIV_W-1:0]    srv_pow;
    logic [hcs_pkg::DIV_W-1:0]    srv_rem;
    logic [BKT_W-1:0]             bkt_rd_addr;
    logic [FILL_W-1:0]            bkt_fill;
    logic [HEAD_W-1:0]            bkt_head;
    logic [SUM_W-1:0]             slot_sum;
    logic [HEAD_W-1:0]            slot;
    logic [ST_W-1:0]              store_wr_addr;
    logic [ST_W-1:0]              store_rd_addr;
    logic [HEAD_W-1:0]            head_inc;
    logic [PEND_W:0]              list_wr_pos;
    logic                         list_wr_ok;
    logic                         bkt_we;
    logic [BKT_ENT_W-1:0]         bkt_wdata;

    assign fid_in    = s_tdata[hcs_pkg::FLOW_W-1:0];
    assign handle_in = s_tdata[hcs_pkg::FLOW_W +: hcs_pkg::HANDLE_W];

    // Flow table entry; a flow never written reads as zero.
    assign flow_last = flow_rd_vld_reg ? flow_rd_reg[FLOW_ENT_W-1:LVL_W] : '0;
    assign flow_lvl  = flow_rd_vld_reg ? flow_rd_reg[LVL_W-1:0] : '0;

    // Departure round and burst check.
    assign last_max = (flow_last > round_now_reg) ? flow_last : round_now_reg;
    assign dep_next = {1'b0, last_max}
                    + DEP_W'(weight_reg[fid_reg[hcs_pkg::WSEL_W-1:0]]);
    assign gap      = dep_reg - {1'b0, round_now_reg};

    // One level of the climb per cycle.
    assign climb_diff = (d_reg >> hcs_pkg::LOG_F) - (c_reg >> hcs_pkg::LOG_F);
    assign enq_bucket = bucket_of(lvl_reg, d_reg[hcs_pkg::LOG_F],
                                  d_reg[hcs_pkg::LOG_F-1:0]);

    // Bucket served at the current round and level, and its divider.
    assign srv_shift  = round_now_reg >> (hcs_pkg::LOG_F * lvl_reg);
    assign srv_bucket = bucket_of(lvl_reg, srv_shift[hcs_pkg::LOG_F],
                                  srv_shift[hcs_pkg::LOG_F-1:0]);
    assign srv_pow    = hcs_pkg::DIV_W'(1) << (hcs_pkg::LOG_F * lvl_reg);
    assign srv_rem    = round_now_reg[hcs_pkg::DIV_W-1:0] & (srv_pow - hcs_pkg::DIV_W'(1));

    // Bucket state; a bucket never written reads as empty.
    assign bkt_rd_addr = cmd.srv_rd ? srv_bucket : enq_bucket;
    assign bkt_fill    = bkt_rd_vld_reg ? bkt_rd_reg[FILL_W-1:0] : '0;
    assign bkt_head    = bkt_rd_vld_reg ? bkt_rd_reg[FILL_W +: HEAD_W] : '0;

    // Bucket slots form a ring; the tail slot wraps past the last slot.
    assign slot_sum      = SUM_W'(bkt_head) + SUM_W'(bkt_fill);
    assign slot          = (slot_sum >= SUM_W'(BUCKET_SLOTS))
                         ? HEAD_W'(slot_sum - SUM_W'(BUCKET_SLOTS)) : HEAD_W'(slot_sum);
    assign store_wr_addr = ST_W'(bucket_reg * BUCKET_SLOTS + slot);
    assign store_rd_addr = ST_W'(bucket_reg * BUCKET_SLOTS + bhead_reg);
    assign head_inc      = (bhead_reg == HEAD_W'(BUCKET_SLOTS - 1))
                         ? '0 : HEAD_W'(bhead_reg + 1'b1);

    assign list_wr_pos = (PEND_W + 1)'(list_head_reg) + (PEND_W + 1)'(list_fill_reg);
    assign list_wr_ok  = list_wr_pos < (PEND_W + 1)'(STORE_DEPTH);

    assign bkt_we    = cmd.enq_commit | cmd.srv_wb;
    assign bkt_wdata = cmd.enq_commit ? {bkt_head, FILL_W'(bkt_fill + 1'b1)}
                                      : {bhead_reg, bfill_reg};

    // Status flags.
    always_comb begin
        stat.burst_drop   = gap >= DEP_W'(burst_reg);
        stat.climb_gt     = climb_diff > DEP_W'(!lvl0_top_reg);
        stat.climb_top    = lvl_reg == LVL_W'(hcs_pkg::TOP_LEVEL);
        stat.bucket_full  = bkt_fill >= FILL_W'(BUCKET_SLOTS);
        stat.pending_zero = pending_reg == '0;
        stat.list_empty   = list_fill_reg == '0;
        stat.take_more    = (bfill_reg != '0) && (acc_reg < hcs_pkg::ACC_W'(occ_reg));
        stat.level_end    = (lvl_reg != LVL_W'(hcs_pkg::TOP_LEVEL))
                         && ((list_fill_reg == pending_reg) || (lvl_reg == '0));
        stat.scan_more    = (list_fill_reg == '0)
                         && ((scanned_reg + 1'b1) < hcs_pkg::SCAN_W'(hcs_pkg::SCAN_LIMIT));
        stat.out_free     = !m_valid_reg || m_tready;
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < hcs_pkg::WEIGHT_SLOTS; i++) begin
                weight_reg[i] <= hcs_pkg::REG_W'(1);
            end
            burst_reg <= hcs_pkg::REG_W'(64);
        end else if (cfg_wen) begin
            case (cfg_index)
                hcs_pkg::CFG_WEIGHT0: weight_reg[0] <= cfg_wdata;
                hcs_pkg::CFG_WEIGHT1: weight_reg[1] <= cfg_wdata;
                hcs_pkg::CFG_WEIGHT2: weight_reg[2] <= cfg_wdata;
                hcs_pkg::CFG_WEIGHT3: weight_reg[3] <= cfg_wdata;
                hcs_pkg::CFG_BURST:   burst_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Scheduler counters, valid bits and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_now_reg <= '0;
            pending_reg   <= '0;
            list_fill_reg <= '0;
            list_head_reg <= '0;
            scanned_reg   <= '0;
            flow_vld_reg  <= '0;
            bkt_vld_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.climb_done) begin
                flow_vld_reg[fid_reg] <= 1'b1;
            end
            if (bkt_we) begin
                bkt_vld_reg[bucket_reg] <= 1'b1;
            end
            if (cmd.enq_commit) begin
                pending_reg <= pending_reg + 1'b1;
            end
            if (cmd.deq_start) begin
                list_head_reg <= '0;
                scanned_reg   <= '0;
            end
            if (cmd.srv_move && list_wr_ok) begin
                list_fill_reg <= list_fill_reg + 1'b1;
            end
            if (cmd.round_inc) begin
                round_now_reg <= round_now_reg + 1'b1;
                scanned_reg   <= scanned_reg + 1'b1;
            end
            if (cmd.pop_wr) begin
                list_fill_reg <= list_fill_reg - 1'b1;
                pending_reg   <= pending_reg - 1'b1;
                if (list_fill_reg == PEND_W'(1)) begin
                    list_head_reg <= '0;
                end else begin
                    list_head_reg <= list_head_reg + 1'b1;
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            fid_reg        <= fid_in;
            handle_reg     <= handle_in;
            out_handle_reg <= '0;
        end
        if (cmd.enq_dep) begin
            dep_reg      <= dep_next;
            lvl_reg      <= flow_lvl;
            lvl0_top_reg <= flow_lvl == LVL_W'(hcs_pkg::TOP_LEVEL);
        end
        if (cmd.enq_chk) begin
            d_reg <= dep_reg >> (hcs_pkg::LOG_F * lvl_reg);
            c_reg <= {1'b0, round_now_reg} >> (hcs_pkg::LOG_F * lvl_reg);
        end
        if (cmd.climb_step) begin
            lvl_reg <= LVL_W'(lvl_reg + 1'b1);
            d_reg   <= d_reg >> hcs_pkg::LOG_F;
            c_reg   <= c_reg >> hcs_pkg::LOG_F;
        end
        if (cmd.climb_done) begin
            bucket_reg <= enq_bucket;
        end
        if (cmd.deq_start || cmd.round_inc) begin
            lvl_reg <= LVL_W'(hcs_pkg::TOP_LEVEL);
        end
        if (cmd.lvl_dec) begin
            lvl_reg <= LVL_W'(lvl_reg - 1'b1);
        end
        if (cmd.srv_rd) begin
            bucket_reg <= srv_bucket;
            div_reg    <= srv_pow - srv_rem;
        end
        if (cmd.srv_occ) begin
            bfill_reg <= bkt_fill;
            bhead_reg <= bkt_head;
            occ_reg   <= bkt_fill;
            acc_reg   <= '0;
        end
        if (cmd.srv_move) begin
            bfill_reg <= FILL_W'(bfill_reg - 1'b1);
            bhead_reg <= head_inc;
            acc_reg   <= acc_reg + hcs_pkg::ACC_W'(div_reg);
        end
        if (cmd.pop_wr) begin
            out_handle_reg <= list_rd_reg;
        end
        if (cmd.status_we) begin
            status_reg <= cmd.status;
        end
        if (cmd.load_out) begin
            m_user_reg <= status_reg;
            m_data_reg <= {round_now_reg, out_handle_reg};
        end
    end

    // Flow table memory.
    always_ff @(posedge aclk) begin
        if (cmd.climb_done) begin
            flow_mem[fid_reg] <= {dep_reg[hcs_pkg::ROUND_W-1:0], lvl_reg};
        end
        flow_rd_reg     <= flow_mem[fid_in];
        flow_rd_vld_reg <= flow_vld_reg[fid_in];
    end

    // Bucket head and fill memory.
    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bkt_mem[bucket_reg] <= bkt_wdata;
        end
        bkt_rd_reg     <= bkt_mem[bkt_rd_addr];
        bkt_rd_vld_reg <= bkt_vld_reg[bkt_rd_addr];
    end

    // Bucket slot memory.
    always_ff @(posedge aclk) begin
        if (cmd.enq_commit) begin
            store_mem[store_wr_addr] <= handle_reg;
        end
        store_rd_reg <= store_mem[store_rd_addr];
    end

    // Round list memory.
    always_ff @(posedge aclk) begin
        if (cmd.srv_move && list_wr_ok) begin
            list_mem[ST_W'(list_wr_pos)] <= store_rd_reg;
        end
        list_rd_reg <= list_mem[ST_W'(list_head_reg)];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[rtl/hierarchical_calendar_scheduler_core.sv]
// Channel | Direction | tdata (low bit up)                   | tuser
// s_      | in        | flow_id[5:0], packet_handle[21:6]    | op
// m_      | out       | out_handle[15:0], serve_round[47:16] | status
// cfg_    | in        | register write: cfg_wen, cfg_index, cfg_wdata
//
// One item at a time. An enqueue reads the flow entry, checks the burst limit, then climbs
// one level at a time and writes the bucket; a burst drop ends after the check. A dequeue
// from a filled round list pops the list head, and one with nothing pending ends at once.
// When the list is empty, rounds are scanned first, each serving one bucket per level.
// Reset is synchronous; valid bits clear the flow and bucket tables at once.
// A stalled receiver holds the item in its last cycle until the output register frees;
// a result waits in the output register while the next input is taken.
module hierarchical_calendar_scheduler_core #(
    parameter int BUCKET_SLOTS = hcs_pkg::DEF_BUCKET_SLOTS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // flow_id, packet_handle
    input  logic [hcs_pkg::IN_DATA_W-1:0]     s_tdata,
    // op
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_handle, serve_round
    output logic [hcs_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [hcs_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                              cfg_wen,
    input  logic [hcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hcs_pkg::REG_W-1:0]         cfg_wdata
);

    hcs_pkg::cmd_t  cmd;
    hcs_pkg::stat_t stat;

    hcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hcs_datapath #(
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item was in progress");

    // Only a dequeue carries a packet handle.
    a_handle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != 3'(hcs_pkg::ST_DEQUEUED))
            |-> m_tdata[hcs_pkg::HANDLE_W-1:0] == '0)
        else $error("handle set on a result that is not a dequeue");

    // Every result carries one of the defined status codes.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= 3'(hcs_pkg::ST_EMPTY))
        else $error("result carries an unknown status");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int SLOTS             = hcs_pkg::DEF_BUCKET_SLOTS;
    localparam int BUCKET_COUNT      = hcs_pkg::BUCKET_COUNT;
    localparam int LIST_DEPTH        = BUCKET_COUNT * SLOTS;
    localparam int PHASE_ITEMS       = 240;
    localparam int HANDLE_W          = hcs_pkg::HANDLE_W;
    localparam int ROUND_W           = hcs_pkg::ROUND_W;
    localparam int REG_W             = hcs_pkg::REG_W;
    localparam int FLOW_W            = hcs_pkg::FLOW_W;
    localparam int FLOW_SLOTS        = hcs_pkg::FLOW_SLOTS;
    localparam int WEIGHT_SLOTS      = hcs_pkg::WEIGHT_SLOTS;
    localparam int BUCKETS_PER_LEVEL = hcs_pkg::BUCKETS_PER_LEVEL;
    localparam int LEVEL_COUNT       = hcs_pkg::LEVEL_COUNT;
    localparam int TOP_LEVEL         = hcs_pkg::TOP_LEVEL;
    localparam int SCAN_LIMIT        = hcs_pkg::SCAN_LIMIT;
    localparam int STATUS_W          = hcs_pkg::STATUS_W;
    localparam int IN_DATA_W         = hcs_pkg::IN_DATA_W;
    localparam int OUT_DATA_W        = hcs_pkg::OUT_DATA_W;
    localparam int CFG_IDX_W         = hcs_pkg::CFG_IDX_W;

    // One expected result of the scheduler.
    typedef struct {
        hcs_pkg::status_t    status;
        logic [HANDLE_W-1:0] handle;
        logic [ROUND_W-1:0]  round;
    } sched_result_t;

    // Scoreboard: a private copy of the calendar state predicts every result.
    class sched_scoreboard;
        logic [REG_W-1:0]    weight [WEIGHT_SLOTS];
        logic [REG_W-1:0]    burst;
        logic [ROUND_W-1:0]  round_now;
        int                  pending;
        logic [ROUND_W-1:0]  flow_last [FLOW_SLOTS];
        int                  flow_lvl [FLOW_SLOTS];
        int                  fill [BUCKET_COUNT];
        logic [HANDLE_W-1:0] store [BUCKET_COUNT][SLOTS];
        logic [HANDLE_W-1:0] departures [LIST_DEPTH];
        int                  dep_fill;
        int                  dep_head;
        sched_result_t       pending_results [$];
        int                  mismatches;

        function new();
            for (int i = 0; i < WEIGHT_SLOTS; i++) weight[i] = 1;
            burst = 64;
            round_now = 0;
            pending = 0;
            for (int i = 0; i < FLOW_SLOTS; i++) begin
                flow_last[i] = 0;
                flow_lvl[i] = 0;
            end
            for (int i = 0; i < BUCKET_COUNT; i++) fill[i] = 0;
            dep_fill = 0;
            dep_head = 0;
            mismatches = 0;
        endfunction

        function void write_reg(hcs_pkg::cfg_index_t idx, logic [REG_W-1:0] value);
            if (idx == hcs_pkg::CFG_BURST) burst = value;
            else weight[idx] = value;
        endfunction

        // Serve one bucket of a level for round r.
        function void serve_level(int lvl, longint unsigned r);
            longint unsigned p, idx, divider, count;
            int bank, b;
            p = 1;
            for (int i = 0; i < lvl; i++) p = p * BUCKETS_PER_LEVEL;
            idx = (r / p) % BUCKETS_PER_LEVEL;
            divider = p - (r % p);
            if (lvl == TOP_LEVEL) bank = 2 * TOP_LEVEL;
            else bank = 2 * lvl + int'((r / p / BUCKETS_PER_LEVEL) & 1);
            b = bank * BUCKETS_PER_LEVEL + int'(idx);
            count = (fill[b] + divider - 1) / divider;
            while (fill[b] > 0 && count > 0) begin
                if (dep_head + dep_fill < LIST_DEPTH) begin
                    departures[dep_head + dep_fill] = store[b][0];
                    dep_fill++;
                end
                for (int s = 0; s < SLOTS - 1; s++) store[b][s] = store[b][s+1];
                fill[b]--;
                count--;
            end
        endfunction

        function void serve_round();
            serve_level(TOP_LEVEL, round_now);
            for (int lvl = LEVEL_COUNT - 2; lvl >= 0; lvl--) begin
                serve_level(lvl, round_now);
                if (dep_fill == pending) return;
            end
        endfunction

        function hcs_pkg::status_t enqueue(int fid, logic [HANDLE_W-1:0] handle);
            longint unsigned now, last, dep, d, c, allowed;
            int lvl, bank, b;
            now = round_now;
            last = (flow_last[fid] > round_now) ? flow_last[fid] : now;
            dep = last + weight[fid % WEIGHT_SLOTS];
            if (dep - now >= burst) return hcs_pkg::ST_BURST_DROP;
            lvl = flow_lvl[fid];
            d = dep;
            c = now;
            for (int i = 0; i < lvl; i++) begin
                d = d / BUCKETS_PER_LEVEL;
                c = c / BUCKETS_PER_LEVEL;
            end
            allowed = (lvl == TOP_LEVEL) ? 0 : 1;
            // Climb until the departure falls within the allowed window.
            while (d / BUCKETS_PER_LEVEL - c / BUCKETS_PER_LEVEL > allowed) begin
                lvl++;
                if (lvl >= LEVEL_COUNT) break;
                d = d / BUCKETS_PER_LEVEL;
                c = c / BUCKETS_PER_LEVEL;
            end
            if (lvl >= LEVEL_COUNT) return hcs_pkg::ST_LEVEL_DROP;
            flow_last[fid] = dep[ROUND_W-1:0];
            if (lvl > flow_lvl[fid]) flow_lvl[fid] = lvl;
            if (lvl == TOP_LEVEL) bank = 2 * TOP_LEVEL;
            else bank = 2 * lvl + int'((d / BUCKETS_PER_LEVEL) & 1);
            b = bank * BUCKETS_PER_LEVEL + int'(d % BUCKETS_PER_LEVEL);
            if (fill[b] >= SLOTS) return hcs_pkg::ST_BUCKET_FULL;
            store[b][fill[b]] = handle;
            fill[b]++;
            pending++;
            return hcs_pkg::ST_QUEUED;
        endfunction

        // Note an accepted input transfer and queue its expected result.
        function void note_input(logic op, int fid, logic [HANDLE_W-1:0] handle);
            sched_result_t r;
            int scanned;
            r.handle = 0;
            if (op == 1'b0) begin
                r.status = enqueue(fid, handle);
            end else if (pending == 0) begin
                r.status = hcs_pkg::ST_EMPTY;
            end else begin
                if (dep_fill == 0) begin
                    scanned = 0;
                    dep_head = 0;
                    while (dep_fill == 0 && scanned < SCAN_LIMIT) begin
                        serve_round();
                        round_now++;
                        scanned++;
                    end
                    round_now--;
                end
                if (dep_fill == 0) begin
                    r.status = hcs_pkg::ST_EMPTY;
                end else begin
                    r.handle = departures[dep_head];
                    dep_head++;
                    dep_fill--;
                    if (dep_fill == 0) dep_head = 0;
                    pending--;
                    r.status = hcs_pkg::ST_DEQUEUED;
                end
            end
            r.round = round_now;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Compare an output transfer with the oldest expectation.
        function void check_result(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] handle,
                                   logic [ROUND_W-1:0] round);
            sched_result_t e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d handle %h round %0d",
                             st, handle, round);
                return;
            end
            e = pending_results[0];
            pending_results.delete(0);
            if (st !== e.status || handle !== e.handle || round !== e.round) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected status %0d handle %h round %0d, got %0d %h %0d",
                             e.status, e.handle, e.round, st, handle, round);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [REG_W-1:0]      cfg_wdata;

    sched_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    hierarchical_calendar_scheduler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Receiver stalls at random.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every output transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[HANDLE_W-1:0], m_tdata[HANDLE_W +: ROUND_W]);
    end

    // Drive one input transfer; called right after a rising edge.
    task automatic send_item(logic op, logic [FLOW_W-1:0] fid, logic [HANDLE_W-1:0] handle);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({handle, fid});
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, int'(fid), handle);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Wait until every expected result has arrived, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(hcs_pkg::cfg_index_t idx, logic [REG_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [REG_W-1:0] w0, logic [REG_W-1:0] w1, logic [REG_W-1:0] w2,
                            logic [REG_W-1:0] w3, logic [REG_W-1:0] bl);
        write_reg(hcs_pkg::CFG_WEIGHT0, w0);
        write_reg(hcs_pkg::CFG_WEIGHT1, w1);
        write_reg(hcs_pkg::CFG_WEIGHT2, w2);
        write_reg(hcs_pkg::CFG_WEIGHT3, w3);
        write_reg(hcs_pkg::CFG_BURST, bl);
    endtask

    // Random traffic: a random mix of enqueues and dequeues, enq_pct percent of them enqueues.
    task automatic random_phase(int items, int enq_pct);
        for (int i = 0; i < items; i++)
            send_item($urandom_range(99) >= enq_pct,
                      FLOW_W'($urandom_range(FLOW_SLOTS - 1)),
                      HANDLE_W'($urandom_range(16'hFFFF)));
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = hcs_pkg::CFG_WEIGHT0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty dequeue, field extremes, a full bucket, then draining.
        send_item(1'b1, 6'd0, 16'h0000);
        send_item(1'b0, 6'd0, 16'h0000);
        send_item(1'b0, 6'd63, 16'hFFFF);
        send_item(1'b1, 6'd0, 16'h0000);
        send_item(1'b1, 6'd0, 16'h0000);
        send_item(1'b1, 6'd0, 16'h0000);
        for (int f = 0; f < 18; f++) send_item(1'b0, 6'(f * 3), 16'(f + 16'h100));
        drain();

        // Burst and level drops at the register extremes.
        set_regs(16'd1, 16'hFFFF, 16'd2, 16'd40000, 16'hFFFF);
        send_item(1'b0, 6'd1, 16'h1234);
        send_item(1'b0, 6'd3, 16'h5678);
        send_item(1'b0, 6'd2, 16'hAAAA);
        send_item(1'b1, 6'd0, 16'h0000);
        drain();
        set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(1'b0, 6'd5, 16'h5555);
        send_item(1'b1, 6'd0, 16'h0000);
        drain();

        // Random phases under changing settings and idling patterns.
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            if (p == 7)
                set_regs(16'd1, 16'd3, 16'd200, 16'hFFFF, 16'd600);
            else
                set_regs(REG_W'($urandom_range(1, 8)), REG_W'($urandom_range(1, 8)),
                         REG_W'($urandom_range(1, 12)), REG_W'($urandom_range(1, 20)),
                         REG_W'($urandom_range(8, 160)));
            random_phase(PHASE_ITEMS / 2, 75);
            random_phase(PHASE_ITEMS / 2, 40);
            drain();
        end

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #100000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/hcs_pkg.sv
rtl/hcs_ctrl.sv
rtl/hcs_datapath.sv
rtl/hierarchical_calendar_scheduler_core.sv
verif/tb.sv
